// ----- sv/sfr_pkg.sv -----
package sfr_pkg;

   localparam int unsigned MAX_RAW_DEFAULT     = 64;
   localparam int unsigned MAX_PAYLOAD_DEFAULT = 60;

   localparam logic [7:0] HEAD_BYTE = 8'h21;

   typedef enum logic [1:0] {
      PH_HUNT1 = 2'd0,
      PH_HUNT2 = 2'd1,
      PH_BODY  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      S_RX    = 2'd0,
      S_FETCH = 2'd1,
      S_SEND  = 2'd2
   } state_type;

   typedef struct packed {
      logic take;
      logic clr_idx;
      logic rd_en;
      logic inc_idx;
   } cmd_type;

   typedef struct packed {
      logic frame_ok;
      logic empty;
      logic last;
   } status_type;

endpackage

// ----- sv/sfr_ram.sv -----
module sfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 60
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sfr_datapath.sv -----
module sfr_datapath #(
   parameter int unsigned MAX_RAW     = sfr_pkg::MAX_RAW_DEFAULT,
   parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  sfr_pkg::cmd_type    cmd,
   output sfr_pkg::status_type status,
   input  logic [7:0]         rx_byte,
   output logic [7:0]         data_byte,
   output logic [5:0]         payload_len,
   output logic               is_last
);

   localparam int unsigned RAW_W = $clog2(MAX_RAW + 1);
   localparam int unsigned DEC_W = $clog2(MAX_PAYLOAD + 2);
   localparam int unsigned AW    = $clog2(MAX_PAYLOAD);

   sfr_pkg::phase_type phase_ff, phase_in;
   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic               esc_ff, esc_in;
   logic               skip_ff, skip_in;
   logic [DEC_W-1:0]   dec_ff, dec_in;
   logic [7:0]         expected_ff, expected_in;
   logic [7:0]         len_ff, len_in;
   logic [7:0]         sum_ff, sum_in;
   logic [AW-1:0]      idx_ff, idx_in;

   logic               done;
   logic               wr_en;
   logic               frame_ok;
   logic               len_zero;
   logic [DEC_W-1:0]   wr_pos;
   logic [DEC_W-1:0]   dec_m1;
   logic [RAW_W-1:0]   raw_inc;
   logic [7:0]         ram_q;

   assign wr_pos  = dec_ff - DEC_W'(2);
   assign dec_m1  = dec_ff - DEC_W'(1);
   assign raw_inc = raw_ff + RAW_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      raw_in      = raw_ff;
      esc_in      = esc_ff;
      skip_in     = skip_ff;
      dec_in      = dec_ff;
      expected_in = expected_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      done        = 1'b0;
      wr_en       = 1'b0;
      frame_ok    = 1'b0;

      if (skip_ff) begin
         skip_in = 1'b0;
      end else if (phase_ff != sfr_pkg::PH_BODY) begin
         if (phase_ff == sfr_pkg::PH_HUNT2 && rx_byte == sfr_pkg::HEAD_BYTE) begin
            phase_in = sfr_pkg::PH_BODY;
            raw_in   = RAW_W'(2);
            esc_in   = 1'b0;
            dec_in   = '0;
         end else if (phase_ff == sfr_pkg::PH_HUNT1 && rx_byte == sfr_pkg::HEAD_BYTE) begin
            phase_in = sfr_pkg::PH_HUNT2;
         end else begin
            phase_in = sfr_pkg::PH_HUNT1;
         end
      end else begin
         raw_in = raw_inc;
         if (esc_ff) begin
            esc_in = 1'b0;
         end else begin
            esc_in = (rx_byte == sfr_pkg::HEAD_BYTE);
            dec_in = dec_ff + DEC_W'(1);
            if (dec_ff == '0) begin
               expected_in = rx_byte;
            end else if (dec_ff == DEC_W'(1)) begin
               len_in = rx_byte;
               sum_in = rx_byte;
               if (rx_byte == 8'd0) begin
                  done = 1'b1;
               end
            end else begin
               wr_en  = 1'b1;
               sum_in = sum_ff + rx_byte;
               // i + 1 >= length, with i = decoded count - 2
               if (9'(dec_m1) >= {1'b0, len_ff}) begin
                  done = 1'b1;
               end
            end
         end

         if (!esc_ff && dec_ff == DEC_W'(1) && rx_byte > 8'(MAX_PAYLOAD)) begin
            phase_in = sfr_pkg::PH_HUNT1;
            raw_in   = '0;
            esc_in   = 1'b0;
            dec_in   = '0;
         end else if (done) begin
            skip_in  = esc_in;
            phase_in = sfr_pkg::PH_HUNT1;
            raw_in   = '0;
            esc_in   = 1'b0;
            dec_in   = '0;
            frame_ok = (sum_in == expected_ff);
         end else if (raw_inc >= RAW_W'(MAX_RAW)) begin
            phase_in = sfr_pkg::PH_HUNT1;
            raw_in   = '0;
            esc_in   = 1'b0;
            dec_in   = '0;
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.clr_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sfr_pkg::PH_HUNT1;
         raw_ff      <= '0;
         esc_ff      <= 1'b0;
         skip_ff     <= 1'b0;
         dec_ff      <= '0;
         expected_ff <= '0;
         len_ff      <= '0;
         sum_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         if (cmd.take) begin
            phase_ff    <= phase_in;
            raw_ff      <= raw_in;
            esc_ff      <= esc_in;
            skip_ff     <= skip_in;
            dec_ff      <= dec_in;
            expected_ff <= expected_in;
            len_ff      <= len_in;
            sum_ff      <= sum_in;
         end
         idx_ff <= idx_in;
      end
   end

   sfr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.take & wr_en),
      .wr_addr (wr_pos[AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_q)
   );

   assign len_zero = (len_ff == 8'd0);

   // empty follows the incoming length byte, so a closing empty frame skips the read
   assign status = '{frame_ok: frame_ok,
                     empty:    (len_in == 8'd0),
                     last:     ((9'(idx_ff) + 9'd1) == {1'b0, len_ff})};

   assign data_byte   = len_zero ? 8'd0 : ram_q;
   assign payload_len = len_ff[5:0];
   assign is_last     = len_zero | status.last;

endmodule

// ----- sv/sfr_ctrl.sv -----
module sfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  sfr_pkg::status_type status,
   output sfr_pkg::cmd_type    cmd
);

   sfr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sfr_pkg::S_RX: begin
            if (req_valid && status.frame_ok) begin
               state_in = status.empty ? sfr_pkg::S_SEND : sfr_pkg::S_FETCH;
            end
         end
         sfr_pkg::S_FETCH: begin
            state_in = sfr_pkg::S_SEND;
         end
         sfr_pkg::S_SEND: begin
            if (rsp_ready) begin
               state_in = (status.empty || status.last) ? sfr_pkg::S_RX : sfr_pkg::S_FETCH;
            end
         end
         default: begin
            state_in = sfr_pkg::S_RX;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         sfr_pkg::S_RX: begin
            req_ready   = 1'b1;
            cmd.take    = req_valid;
            cmd.clr_idx = 1'b1;
         end
         sfr_pkg::S_FETCH: begin
            cmd.rd_en = 1'b1;
         end
         sfr_pkg::S_SEND: begin
            rsp_valid   = 1'b1;
            cmd.inc_idx = rsp_ready & ~status.last & ~status.empty;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfr_pkg::S_RX;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/stuffed_frame_receiver.sv -----
// Takes one raw byte per cycle while hunting or parsing a frame.
// A verified frame stalls the input while its payload is read back from the
// buffer RAM: each payload byte passes a FETCH state (registered RAM read),
// then a SEND state that offers the beat and holds until rsp_ready; an empty
// frame goes straight from the closing byte to a single SEND beat.
// Synchronous active-high reset returns to hunting with no frame pending.
module stuffed_frame_receiver #(
   parameter int unsigned MAX_RAW     = sfr_pkg::MAX_RAW_DEFAULT,
   parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic [5:0] rsp_payload_len,
   output logic       rsp_is_last
);

   sfr_pkg::cmd_type    cmd;
   sfr_pkg::status_type status;

   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfr_datapath #(
      .MAX_RAW     (MAX_RAW),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .rx_byte     (req_rx_byte),
      .data_byte   (rsp_data_byte),
      .payload_len (rsp_payload_len),
      .is_last     (rsp_is_last)
   );

endmodule

// ----- sv/sfr_checker.sv -----
module sfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_byte,
   input logic [5:0] rsp_payload_len,
   input logic       rsp_is_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_payload_len) && $stable(rsp_is_last))
      else $error("result beat changed while stalled");

   // input is stalled for the whole release of a frame
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready during release");

   // after the last beat of a frame the input opens again
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_last |=> req_ready && !rsp_valid)
      else $error("input not reopened after last beat");

   // non-last beats are followed by another beat of the same frame
   a_same_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_last |=> ##1 rsp_valid
         && rsp_payload_len == $past(rsp_payload_len, 2))
      else $error("frame length changed within a release");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_payload_len (rsp_payload_len),
   .rsp_is_last     (rsp_is_last)
);
